[src/kwos_pkg.sv]
// Shared types and constants for the kernel weighted offset smoother.
package kwos_pkg;

    localparam int MAX_NEIGHBORS_DEF = 8;

    // Epanechnikov scale in Q0.16
    localparam logic [15:0] SCALE_Q16 = 16'd50727;

    localparam logic CMD_CENTER   = 1'b0;
    localparam logic CMD_NEIGHBOR = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] off_x;
        logic [31:0] off_y;
        logic [31:0] off_z;
        logic        offset_valid;
        logic        last_item;
    } t_cmd_item;

    typedef struct packed {
        logic [31:0] result_x;
        logic [31:0] result_y;
        logic [31:0] result_z;
        logic        result_valid;
        logic        overflow;
    } t_res_item;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] off;
        logic             vld;
    } t_nbr_entry;

endpackage

[src/kernel_weighted_offset_smoother.sv]
// Top level: kernel weighted (Epanechnikov) smoothing of one point's 3-D offset.
//
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. A center command loads position and own offset; neighbor
//   commands follow, one per cycle, and the one marked last_item closes the
//   list. Neighbors past MAX_NEIGHBORS are dropped and reported as overflow.
//   Result channel: o_strobe marks o_result for exactly one cycle; the
//   receiver must take it then (no back pressure).
//   After the last neighbor busy stays high for a bandwidth pass (read,
//   distance, set), then per stored neighbor a read, a distance over three
//   axes, a check, a 16-step bit-serial weight division, a scale step and an
//   accumulate over three axes (a zero weight skips division, scale and
//   accumulate; zero distance skips the division), then three divisions by
//   the weight sum, one per axis. The result strobe comes in the first
//   cycle busy is low again.
//   A center with last_item set answers the next cycle with an all-zero
//   transaction, result_valid low.
//   Reset (synchronous, active low) clears center, count and flags; the
//   neighbor memory is not cleared since only written entries are read.
module kernel_weighted_offset_smoother
    import kwos_pkg::*;
#(
    parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_cmd_item i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_res_item o_result
);

    localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int NUM_W  = 49 + CNT_W;   // signed accumulator with 16 fraction bits (offset times Q0.16 weight)
    localparam int DEN_W  = 17 + CNT_W;   // sum of Q0.16 weights plus one
    localparam int DIST_W = 66;
    localparam int B_W    = 68;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BRD   = 4'd1;
    localparam logic [3:0] ST_BDST  = 4'd2;
    localparam logic [3:0] ST_BSET  = 4'd3;
    localparam logic [3:0] ST_RD    = 4'd4;
    localparam logic [3:0] ST_DST   = 4'd5;
    localparam logic [3:0] ST_WCHK  = 4'd6;
    localparam logic [3:0] ST_QDIV  = 4'd7;
    localparam logic [3:0] ST_WGT   = 4'd8;
    localparam logic [3:0] ST_ACC   = 4'd9;
    localparam logic [3:0] ST_NEXT  = 4'd10;
    localparam logic [3:0] ST_DIVLD = 4'd11;
    localparam logic [3:0] ST_DIV   = 4'd12;

    // Neighbor store: one entry per neighbor, registered read.
    t_nbr_entry r_mem [MAX_NEIGHBORS];
    t_nbr_entry r_rdata;

    logic [3:0]             r_state;
    logic [CNT_W-1:0]       r_count;
    logic                   r_drop;
    logic [2:0][31:0]       r_cpos;
    logic [2:0][31:0]       r_coff;
    logic [IDX_W-1:0]       r_idx;
    logic [1:0]             r_axis;
    logic [4:0]             r_step;
    logic [DIST_W-1:0]      r_dist;
    logic [B_W-1:0]         r_bw;
    logic [B_W-1:0]         r_qrem;
    logic [16:0]            r_q;
    logic [15:0]            r_w;
    logic signed [NUM_W-1:0] r_num [3];
    logic [DEN_W-1:0]       r_den;
    logic [DEN_W-1:0]       r_drem;
    logic [31:0]            r_dlo;
    logic                   r_neg;
    logic [2:0][31:0]       r_res;
    logic                   r_res_valid;
    logic                   r_res_ovf;
    logic                   r_strobe;

    logic                   accept;
    logic                   wr_en;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [IDX_W-1:0]       last_idx;
    logic [CNT_W-1:0]       cnt_m1;
    t_nbr_entry             wr_data;
    logic signed [32:0]     diff;
    logic [32:0]            diff_mag;
    logic [DIST_W-1:0]      sq;
    logic [B_W:0]           q_r2;
    logic                   q_ge;
    logic [32:0]            wprod;
    logic signed [48:0]     woff;
    logic [DEN_W:0]         d_r2;
    logic                   d_ge;
    logic [NUM_W-1:0]       mag;
    logic [31:0]            quo;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && (i_cmd.command == CMD_NEIGHBOR)
                    && (r_count < CNT_W'(MAX_NEIGHBORS));
    assign cnt_m1   = r_count - 1'b1;
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign rd_en    = (r_state == ST_BRD) || (r_state == ST_RD);
    assign rd_addr  = (r_state == ST_BRD) ? last_idx : r_idx;

    always_comb begin
        wr_data.pos = {i_cmd.pos_z, i_cmd.pos_y, i_cmd.pos_x};
        wr_data.off = {i_cmd.off_z, i_cmd.off_y, i_cmd.off_x};
        wr_data.vld = i_cmd.offset_valid;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // shared datapath pieces
    always_comb begin
        diff     = $signed({r_rdata.pos[r_axis][31], r_rdata.pos[r_axis]})
                   - $signed({r_cpos[r_axis][31], r_cpos[r_axis]});
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
        sq       = diff_mag * diff_mag;
        q_r2     = {r_qrem, 1'b0};
        q_ge     = (q_r2 >= {1'b0, r_bw});
        wprod    = {16'b0, r_q} * {17'b0, SCALE_Q16};
        woff     = $signed({1'b0, r_w}) * $signed(r_rdata.off[r_axis]);
        d_r2     = {r_drem, r_dlo[31]};
        d_ge     = (d_r2 >= {1'b0, r_den});
        mag      = r_num[r_axis][NUM_W-1] ? NUM_W'(-r_num[r_axis])
                                          : NUM_W'(r_num[r_axis]);
        quo      = {r_dlo[30:0], d_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_cpos   <= '0;
            r_coff   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        if (i_cmd.command == CMD_CENTER) begin
                            r_cpos  <= {i_cmd.pos_z, i_cmd.pos_y, i_cmd.pos_x};
                            r_coff  <= {i_cmd.off_z, i_cmd.off_y, i_cmd.off_x};
                            r_count <= '0;
                            r_drop  <= 1'b0;
                            if (i_cmd.last_item) begin
                                r_res       <= '0;
                                r_res_valid <= 1'b0;
                                r_res_ovf   <= 1'b0;
                                r_strobe    <= 1'b1;
                            end
                        end else begin
                            if (wr_en) begin
                                r_count <= r_count + 1'b1;
                            end else begin
                                r_drop <= 1'b1;
                            end
                            if (i_cmd.last_item) begin
                                r_state <= ST_BRD;
                            end
                        end
                    end
                end
                ST_BRD: begin
                    r_axis  <= '0;
                    r_dist  <= '0;
                    r_state <= ST_BDST;
                end
                ST_BDST: begin
                    r_dist <= r_dist + sq;
                    r_axis <= r_axis + 1'b1;
                    if (r_axis == 2'd2) begin
                        r_state <= ST_BSET;
                    end
                end
                ST_BSET: begin
                    r_bw  <= {r_dist, 2'b00};
                    r_idx <= '0;
                    r_den <= DEN_W'(17'h10000);
                    for (int k = 0; k < 3; k++) begin
                        r_num[k] <= {{(NUM_W-48){r_coff[k][31]}}, r_coff[k], 16'b0};
                    end
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_axis  <= '0;
                    r_dist  <= '0;
                    r_state <= ST_DST;
                end
                ST_DST: begin
                    r_dist <= r_dist + sq;
                    r_axis <= r_axis + 1'b1;
                    if (r_axis == 2'd2) begin
                        r_state <= ST_WCHK;
                    end
                end
                ST_WCHK: begin
                    // zero weight: invalid, zero bandwidth, or outside kernel
                    if (!r_rdata.vld || (r_bw == '0) || ({2'b00, r_dist} >= r_bw)) begin
                        r_state <= ST_NEXT;
                    end else if (r_dist == '0) begin
                        r_q     <= 17'h10000;
                        r_state <= ST_WGT;
                    end else begin
                        r_qrem  <= r_bw - {2'b00, r_dist};
                        r_q     <= '0;
                        r_step  <= '0;
                        r_state <= ST_QDIV;
                    end
                end
                ST_QDIV: begin
                    r_qrem <= q_ge ? B_W'(q_r2 - {1'b0, r_bw}) : B_W'(q_r2);
                    r_q    <= {r_q[15:0], q_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd15) begin
                        r_state <= ST_WGT;
                    end
                end
                ST_WGT: begin
                    r_w     <= wprod[31:16];
                    r_axis  <= '0;
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_num[r_axis] <= r_num[r_axis] + NUM_W'(woff);
                    if (r_axis == 2'd0) begin
                        r_den <= r_den + DEN_W'(r_w);
                    end
                    r_axis <= r_axis + 1'b1;
                    if (r_axis == 2'd2) begin
                        r_state <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (r_idx == last_idx) begin
                        r_axis  <= '0;
                        r_state <= ST_DIVLD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_RD;
                    end
                end
                ST_DIVLD: begin
                    r_neg   <= r_num[r_axis][NUM_W-1];
                    r_drem  <= mag[NUM_W-1:32];
                    r_dlo   <= mag[31:0];
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_drem <= d_ge ? DEN_W'(d_r2 - {1'b0, r_den}) : DEN_W'(d_r2);
                    r_dlo  <= quo;
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd31) begin
                        r_res[r_axis] <= r_neg ? 32'(-quo) : quo;
                        if (r_axis == 2'd2) begin
                            r_res_valid <= 1'b1;
                            r_res_ovf   <= r_drop;
                            r_strobe    <= 1'b1;
                            r_count     <= '0;
                            r_drop      <= 1'b0;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= ST_DIVLD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe              = r_strobe;
    assign o_result.result_x     = r_res[0];
    assign o_result.result_y     = r_res[1];
    assign o_result.result_z     = r_res[2];
    assign o_result.result_valid = r_res_valid;
    assign o_result.overflow     = r_res_ovf;

endmodule
